### design/nsdu_pkg.sv
`timescale 1ns / 1ps

package nsdu_pkg;

    // Fixed field widths
    localparam int RAD_W   = 50;    // radicand, unsigned Q26.24
    localparam int ROOT_W  = 26;    // root, unsigned Q14.12
    localparam int TOL_W   = 24;    // tolerance, Q.24
    localparam int ERR_W   = 53;    // signed r*r - s
    localparam int DIVR_W  = ROOT_W + 1;  // divisor 2r
    localparam int OUT_W   = 32;    // root padded to whole bytes
    localparam int R0_SHIFT = 13;   // s/2 from Q.24 to Q.12

    localparam logic [TOL_W-1:0]  TOL_RESET = 24'd167772;
    localparam logic [RAD_W-1:0]  RAD_MAX   = {RAD_W{1'b1}};
    localparam logic [ROOT_W-1:0] ROOT_MAX  = {ROOT_W{1'b1}};
    localparam logic [ROOT_W-1:0] ROOT_ONE  = {{(ROOT_W-1){1'b0}}, 1'b1};

    // Opcodes
    localparam logic OP_DIST = 1'b0;
    localparam logic OP_SQRT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SUM,
        ST_INIT,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MS_DX,
        MS_DY,
        MS_R
    } t_mul_sel;

    // Controller -> datapath
    typedef struct packed {
        logic     load_in;
        t_mul_sel mul_sel;
        logic     mul_en;
        logic     sq_hold;
        logic     sum_en;
        logic     init_en;
        logic     chk_en;
        logic     div_start;
        logic     upd_en;
        logic     out_load;
        logic     out_conv;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic s_zero;
        logic tol_met;
        logic div_done;
    } t_sts;

endpackage

### design/nsdu_div.sv
`timescale 1ns / 1ps

module nsdu_div #(
    parameter int N = 53,   // dividend / quotient width
    parameter int D = 27    // divisor width
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [D-1:0] i_divisor,
    output logic         o_done,
    output logic [N-1:0] o_quotient
);

    localparam int CNT_W = $clog2(N + 1);

    logic [D-1:0]     r_rem;
    logic [N-1:0]     r_quo;
    logic [D-1:0]     r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [D:0] trial;
    logic       ge;
    logic [D:0] diff;

    // Restoring division, one quotient bit per cycle
    assign trial = {r_rem, r_quo[N-1]};
    assign ge    = (trial >= {1'b0, r_dvs});
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
            r_cnt <= CNT_W'(N);
        end else if (r_busy) begin
            r_rem <= ge ? diff[D-1:0] : trial[D-1:0];
            r_quo <= {r_quo[N-2:0], ge};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### design/nsdu_datapath.sv
`timescale 1ns / 1ps

module nsdu_datapath #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  nsdu_pkg::t_cmd                      i_cmd,
    output nsdu_pkg::t_sts                      o_sts,
    input  logic                                i_cfg_wr_en,
    input  logic [nsdu_pkg::TOL_W-1:0]          i_cfg_wr_data,
    input  logic signed [COORD_WIDTH-1:0]       i_ax,
    input  logic signed [COORD_WIDTH-1:0]       i_ay,
    input  logic signed [COORD_WIDTH-1:0]       i_bx,
    input  logic signed [COORD_WIDTH-1:0]       i_by,
    input  logic [nsdu_pkg::RAD_W-1:0]          i_radicand,
    output logic [nsdu_pkg::ROOT_W-1:0]         o_root,
    output logic                                o_converged
);

    import nsdu_pkg::*;

    localparam int DW = COORD_WIDTH + 1;                 // |difference| width
    localparam int MW = (DW > ROOT_W) ? DW : ROOT_W;     // multiplier operand
    localparam int PW = 2 * MW;                          // product width

    logic [TOL_W-1:0]  r_tol;
    logic [DW-1:0]     r_dx;
    logic [DW-1:0]     r_dy;
    logic [RAD_W-1:0]  r_s;
    logic [RAD_W-1:0]  r_sqa;
    logic [PW-1:0]     r_prod;
    logic [ROOT_W-1:0] r_r;
    logic              r_neg;
    logic [ROOT_W-1:0] r_out_root;
    logic              r_out_conv;

    logic signed [DW-1:0] dx_diff;
    logic signed [DW-1:0] dy_diff;
    logic [MW-1:0]        mul_op;
    logic [RAD_W-1:0]     prod_sat;
    logic [RAD_W:0]       sq_sum;
    logic [RAD_W-R0_SHIFT-1:0] r0_raw;
    logic [ROOT_W-1:0]    r0_clamp;
    logic signed [ERR_W-1:0] err;
    logic                 err_neg;
    logic [ERR_W-1:0]     err_mag;
    logic [ERR_W-1:0]     quo;
    logic [ERR_W:0]       up_sum;
    logic [ROOT_W-1:0]    r_upd;
    logic                 div_done;

    // Tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    // Coordinate differences, signed; only the magnitude is registered
    assign dx_diff = DW'(i_bx) - DW'(i_ax);
    assign dy_diff = DW'(i_by) - DW'(i_ay);

    // Shared squaring multiplier operand
    always_comb begin
        case (i_cmd.mul_sel)
            MS_DX:   mul_op = MW'(r_dx);
            MS_DY:   mul_op = MW'(r_dy);
            MS_R:    mul_op = MW'(r_r);
            default: mul_op = MW'(r_r);
        endcase
    end

    assign prod_sat = (r_prod[PW-1:RAD_W] != '0) ? RAD_MAX : r_prod[RAD_W-1:0];
    assign sq_sum   = {1'b0, r_sqa} + {1'b0, prod_sat};

    // Start value s/2 in Q.12, clamped to the root range
    assign r0_raw = r_s[RAD_W-1:R0_SHIFT];
    always_comb begin
        if (r0_raw[RAD_W-R0_SHIFT-1:ROOT_W] != '0) begin
            r0_clamp = ROOT_MAX;
        end else if (r0_raw[ROOT_W-1:0] == '0) begin
            r0_clamp = ROOT_ONE;
        end else begin
            r0_clamp = r0_raw[ROOT_W-1:0];
        end
    end

    // Error r*r - s and its magnitude
    assign err     = $signed({1'b0, r_prod[ERR_W-2:0]}) - $signed({3'b0, r_s});
    assign err_neg = err[ERR_W-1];
    assign err_mag = err_neg ? ERR_W'(-err) : ERR_W'(err);

    // Step r - q with q truncated toward zero, clamped
    assign up_sum = {{(ERR_W+1-ROOT_W){1'b0}}, r_r} + {1'b0, quo};
    always_comb begin
        if (r_neg) begin
            r_upd = (up_sum[ERR_W:ROOT_W] != '0) ? ROOT_MAX : up_sum[ROOT_W-1:0];
        end else if (quo >= ERR_W'(r_r)) begin
            r_upd = ROOT_ONE;
        end else begin
            r_upd = r_r - quo[ROOT_W-1:0];
        end
    end

    nsdu_div #(
        .N(ERR_W),
        .D(DIVR_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (err_mag),
        .i_divisor  ({r_r, 1'b0}),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_dx <= dx_diff[DW-1] ? DW'(-dx_diff) : DW'(dx_diff);
            r_dy <= dy_diff[DW-1] ? DW'(-dy_diff) : DW'(dy_diff);
            r_s  <= i_radicand;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_op * mul_op;
        end
        if (i_cmd.sq_hold) begin
            r_sqa <= prod_sat;
        end
        if (i_cmd.sum_en) begin
            r_s <= sq_sum[RAD_W] ? RAD_MAX : sq_sum[RAD_W-1:0];
        end
        if (i_cmd.init_en) begin
            r_r <= (r_s == '0) ? '0 : r0_clamp;
        end else if (i_cmd.upd_en) begin
            r_r <= r_upd;
        end
        if (i_cmd.chk_en) begin
            r_neg <= err_neg;
        end
        if (i_cmd.out_load) begin
            r_out_root <= r_r;
            r_out_conv <= i_cmd.out_conv;
        end
    end

    assign o_sts.s_zero   = (r_s == '0);
    assign o_sts.tol_met  = (err_mag <= ERR_W'(r_tol));
    assign o_sts.div_done = div_done;

    assign o_root      = r_out_root;
    assign o_converged = r_out_conv;

endmodule

### design/nsdu_ctrl.sv
`timescale 1ns / 1ps

module nsdu_ctrl #(
    parameter int MAX_ITERATIONS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_opcode,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  nsdu_pkg::t_sts i_sts,
    output nsdu_pkg::t_cmd o_cmd
);

    import nsdu_pkg::*;

    localparam int IT_W = $clog2(MAX_ITERATIONS + 1);

    t_state          r_state;
    t_state          n_state;
    logic [IT_W-1:0] r_iter;
    logic [IT_W-1:0] n_iter;
    logic            r_conv;
    logic            n_conv;
    logic            r_out_valid;

    // State, step count and output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_iter      <= '0;
            r_conv      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            r_conv  <= n_conv;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_iter     = r_iter;
        n_conv     = r_conv;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul_sel  = MS_R;
        o_cmd.out_conv = r_conv;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = (i_opcode == OP_SQRT) ? ST_INIT : ST_SQ_X;
                end
            end
            ST_SQ_X: begin
                o_cmd.mul_sel = MS_DX;
                o_cmd.mul_en  = 1'b1;
                n_state = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                o_cmd.mul_sel = MS_DY;
                o_cmd.mul_en  = 1'b1;
                o_cmd.sq_hold = 1'b1;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state = ST_INIT;
            end
            ST_INIT: begin
                o_cmd.init_en = 1'b1;
                n_iter = '0;
                if (i_sts.s_zero) begin
                    n_conv  = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_sel = MS_R;
                o_cmd.mul_en  = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.chk_en = 1'b1;
                if (i_sts.tol_met) begin
                    n_conv  = 1'b1;
                    n_state = ST_DONE;
                end else if (r_iter == IT_W'(MAX_ITERATIONS)) begin
                    n_conv  = 1'b0;
                    n_state = ST_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_iter  = r_iter + IT_W'(1);
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.upd_en = 1'b1;
                n_state = ST_MUL;
            end
            ST_DONE: begin
                // wait for the output slot to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### design/newton_sqrt_distance_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// s_axis    in         tuser: opcode; tdata: ax, ay, bx, by, radicand (low bits up)
// m_axis    out        tuser: converged; tdata: root
// cfg       in         wr_data: tolerance, written when wr_en is high
//
// One item at a time. Each Newton step squares r, checks the error, divides
// |r*r - s| by 2r in the bit-serial divider and updates r; distance items first
// square and sum the differences, and a zero radicand skips the steps. Up to
// MAX_ITERATIONS steps; the input is ready again in the cycle after the result
// is loaded. Reset is synchronous, active low, and loads the default tolerance.
// The unit stalls before loading a result only while the output register is
// still full.

module newton_sqrt_distance_unit #(
    parameter int MAX_ITERATIONS = 32,
    parameter int COORD_WIDTH    = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // ax, ay, bx, by, radicand from bit 0 up, zero padded
    input  logic [8*((4*COORD_WIDTH+nsdu_pkg::RAD_W+7)/8)-1:0] i_s_axis_tdata,
    // opcode
    input  logic                                  i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // root from bit 0 up, zero padded
    output logic [nsdu_pkg::OUT_W-1:0]            o_m_axis_tdata,
    // converged
    output logic                                  o_m_axis_tuser,
    input  logic                                  i_cfg_wr_en,
    input  logic [nsdu_pkg::TOL_W-1:0]            i_cfg_wr_data
);

    import nsdu_pkg::*;

    localparam int CW = COORD_WIDTH;

    t_cmd              cmd;
    t_sts              sts;
    logic [ROOT_W-1:0] root;
    logic              converged;

    nsdu_ctrl #(
        .MAX_ITERATIONS(MAX_ITERATIONS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_opcode    (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    nsdu_datapath #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_ax          (i_s_axis_tdata[CW-1:0]),
        .i_ay          (i_s_axis_tdata[2*CW-1:CW]),
        .i_bx          (i_s_axis_tdata[3*CW-1:2*CW]),
        .i_by          (i_s_axis_tdata[4*CW-1:3*CW]),
        .i_radicand    (i_s_axis_tdata[4*CW+RAD_W-1:4*CW]),
        .o_root        (root),
        .o_converged   (converged)
    );

    assign o_m_axis_tdata = {{(OUT_W-ROOT_W){1'b0}}, root};
    assign o_m_axis_tuser = converged;

endmodule
